// ===== rtl/assert_macros.svh =====
// Assertion macros used by the allocator top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/nfsa_pkg.sv =====
// Types and constants of the next-free-server allocator.
package nfsa_pkg;
  localparam int MAX_SERVERS = 16;
  localparam int SRV_W       = 4;
  localparam int NUM_W       = 5;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 32;
  localparam int FREE_W      = 33;
  localparam int IN_W        = 64;
  localparam int OUT_W       = 88;

  typedef struct packed {
    logic              is_free;
    logic [FREE_W-1:0] busy_until;
  } alu_res_t;
endpackage

// ===== rtl/nfsa_alu.sv =====
// Shared compare and add unit: free test of one server entry and new free-at time.
module nfsa_alu
  import nfsa_pkg::*;
(
  input  logic [FREE_W-1:0] a_free_at,
  input  logic [TIME_W-1:0] a_now,
  input  logic [TIME_W-1:0] a_load,
  output alu_res_t          res
);

  always_comb begin
    res.is_free    = (a_free_at <= {1'b0, a_now});
    res.busy_until = {1'b0, a_now} + {1'b0, a_load};
  end

endmodule

// ===== rtl/next_free_server_allocator_unit.sv =====
// Top level of the next-free-server allocator: sequencer, server state and result register.
// A request passes through an accept state (IDLE), one scan step per server visited
// (1 to num_servers) and an update state. The scan tests one free-at entry per cycle
// through the shared compare unit from the rotating start position. A result waits in
// the output register while the next request is accepted and scanned; the update stalls
// only if the previous result is still untaken. All server state is held in flip-flops
// and cleared by reset at once.
`include "assert_macros.svh"
module next_free_server_allocator_unit
  import nfsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NUM_W-1:0]  cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [31:0] arrival_time, [63:32] work_load
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // [3:0] server_index, [35:4] server_count, [67:36] max_count, [83:68] busiest_mask, pad
  output logic [OUT_W-1:0]  out_tdata,
  // [0] dropped
  output logic              out_tuser
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [NUM_W-1:0]       num_r;
  logic [SRV_W-1:0]       start_r, start_nxt;
  logic [SRV_W-1:0]       idx_r, idx_nxt;
  logic [SRV_W-1:0]       steps_r, steps_nxt;
  logic                   found_r, found_nxt;
  logic [TIME_W-1:0]      now_r;
  logic [TIME_W-1:0]      load_r;
  logic [FREE_W-1:0]      free_at_r [MAX_SERVERS];
  logic [CNT_W-1:0]       handled_r [MAX_SERVERS];
  logic [CNT_W-1:0]       highest_r, highest_nxt;
  logic [MAX_SERVERS-1:0] mask_r, mask_nxt;
  logic [MAX_SERVERS-1:0] inuse;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r;
  logic                   out_drop_r;
  logic                   commit;
  logic [CNT_W-1:0]       cnt_new;
  logic [NUM_W-1:0]       clamp_num;
  alu_res_t               alu_res;

  nfsa_alu u_alu (
    .a_free_at (free_at_r[idx_r]),
    .a_now     (now_r),
    .a_load    (load_r),
    .res       (alu_res)
  );

  always_comb begin
    if (cfg_wr_data == '0) begin
      clamp_num = NUM_W'(1);
    end else if (cfg_wr_data > NUM_W'(MAX_SERVERS)) begin
      clamp_num = NUM_W'(MAX_SERVERS);
    end else begin
      clamp_num = cfg_wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_SERVERS; i++) begin
      inuse[i] = (NUM_W'(i) < num_r);
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign commit     = (state_r == ST_UPDATE) && (!out_valid_r || out_tready);
  assign cnt_new    = (handled_r[idx_r] == '1) ? handled_r[idx_r] : handled_r[idx_r] + 1'b1;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    steps_nxt   = steps_r;
    found_nxt   = found_r;
    start_nxt   = start_r;
    highest_nxt = highest_r;
    mask_nxt    = mask_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          idx_nxt   = ({1'b0, start_r} < num_r) ? start_r : '0;
          steps_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (alu_res.is_free) begin
          found_nxt = 1'b1;
          state_nxt = ST_UPDATE;
        end else if ({1'b0, steps_r} == num_r - NUM_W'(1)) begin
          state_nxt = ST_UPDATE;
        end else begin
          steps_nxt = steps_r + 1'b1;
          idx_nxt   = ({1'b0, idx_r} + NUM_W'(1) == num_r) ? '0 : idx_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        if (commit) begin
          if (found_r) begin
            if (cnt_new > highest_r) begin
              highest_nxt = cnt_new;
              mask_nxt    = MAX_SERVERS'(1) << idx_r;
            end else if (cnt_new == highest_r) begin
              mask_nxt = mask_r | (MAX_SERVERS'(1) << idx_r);
            end
          end
          start_nxt = ({1'b0, start_r} + NUM_W'(1) >= num_r) ? '0 : start_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      num_r       <= NUM_W'(MAX_SERVERS);
      start_r     <= '0;
      idx_r       <= '0;
      steps_r     <= '0;
      found_r     <= 1'b0;
      highest_r   <= '0;
      mask_r      <= '1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_SERVERS; i++) begin
        free_at_r[i] <= '0;
        handled_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      idx_r       <= idx_nxt;
      steps_r     <= steps_nxt;
      found_r     <= found_nxt;
      highest_r   <= highest_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        num_r <= clamp_num;
      end
      if (commit && found_r) begin
        free_at_r[idx_r] <= alu_res.busy_until;
        handled_r[idx_r] <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      now_r  <= in_tdata[TIME_W-1:0];
      load_r <= in_tdata[2*TIME_W-1:TIME_W];
    end
    if (commit) begin
      out_drop_r <= !found_r;
      out_data_r <= {4'b0000,
                     mask_nxt & inuse,
                     highest_nxt,
                     found_r ? cnt_new : {CNT_W{1'b0}},
                     found_r ? idx_r : {SRV_W{1'b0}}};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_drop_r;

  `ASSERT_CLK(a_accept_starts_scan, (in_tvalid && in_tready) |=> (state_r == ST_SCAN),
              "accepted word did not start a scan")
  `ASSERT_CLK(a_scan_in_ring, (state_r == ST_SCAN) |-> ({1'b0, idx_r} < num_r),
              "scan index outside the ring")
  `ASSERT_CLK(a_drop_clears, (out_tvalid && out_tuser) |-> (out_tdata[35:0] == 36'd0),
              "dropped word carries a server or count")
  `ASSERT_CLK(a_count_le_max, (out_tvalid && !out_tuser) |->
              (out_tdata[35:4] <= out_tdata[67:36]), "server count above max count")
  `ASSERT_CLK(a_mask_in_ring, out_tvalid |-> ((out_tdata[83:68] & ~inuse) == '0),
              "busiest mask marks a server outside the ring")

endmodule

// ===== dv/tb_next_free_server_allocator_unit.sv =====
// Testbench for the next-free-server allocator: stream stimulus, grant prediction and checking.
`timescale 1ns / 1ps
module tb_next_free_server_allocator_unit
  import nfsa_pkg::*;
();

  typedef struct {
    logic [SRV_W-1:0]       server;
    logic                   dropped;
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       top;
    logic [MAX_SERVERS-1:0] mask;
  } grant_t;

  class grant_tracker;
    logic [FREE_W-1:0] free_at [MAX_SERVERS];
    logic [CNT_W-1:0]  handled [MAX_SERVERS];
    logic [CNT_W-1:0]  highest;
    int                start_pos;
    int                ring;
    grant_t            due_grants [$];
    int                errors;
    int                requests;
    int                drops;

    function new();
      foreach (free_at[i]) begin
        free_at[i] = '0;
        handled[i] = '0;
      end
      highest   = '0;
      start_pos = 0;
      ring      = MAX_SERVERS;
      errors    = 0;
      requests  = 0;
      drops     = 0;
    endfunction

    function void set_ring(logic [NUM_W-1:0] v);
      if (v == 0) begin
        ring = 1;
      end else if (v > MAX_SERVERS) begin
        ring = MAX_SERVERS;
      end else begin
        ring = v;
      end
    endfunction

    function void note_request(logic [TIME_W-1:0] arrival, logic [TIME_W-1:0] load);
      grant_t            g;
      int                pick;
      bit                found;
      logic [FREE_W-1:0] now;
      g     = '{default: '0};
      now   = {1'b0, arrival};
      pick  = 0;
      found = 1'b0;
      for (int i = start_pos; i < ring && !found; i++) begin
        if (free_at[i] <= now) begin
          pick  = i;
          found = 1'b1;
        end
      end
      for (int i = 0; i < ring && !found; i++) begin
        if (free_at[i] <= now) begin
          pick  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        free_at[pick] = now + {1'b0, load};
        if (handled[pick] != '1) handled[pick]++;
        if (handled[pick] > highest) highest = handled[pick];
        g.server = pick[SRV_W-1:0];
        g.count  = handled[pick];
      end else begin
        g.dropped = 1'b1;
        drops++;
      end
      g.top = highest;
      for (int i = 0; i < ring; i++) begin
        if (handled[i] == highest) g.mask[i] = 1'b1;
      end
      start_pos = (start_pos + 1 >= ring) ? 0 : start_pos + 1;
      requests++;
      due_grants.push_back(g);
    endfunction

    function int pending_count();
      return due_grants.size();
    endfunction

    function void check_grant(logic [OUT_W-1:0] data, logic user);
      grant_t g;
      if (due_grants.size() == 0) begin
        $error("result word with no request outstanding");
        errors++;
        return;
      end
      g = due_grants.pop_front();
      if (data[3:0] !== g.server) begin
        $error("server_index: expected %0d, actual %0d", g.server, data[3:0]);
        errors++;
      end
      if (user !== g.dropped) begin
        $error("dropped: expected %0d, actual %0d", g.dropped, user);
        errors++;
      end
      if (data[35:4] !== g.count) begin
        $error("server_count: expected %0d, actual %0d", g.count, data[35:4]);
        errors++;
      end
      if (data[67:36] !== g.top) begin
        $error("max_count: expected %0d, actual %0d", g.top, data[67:36]);
        errors++;
      end
      if (data[83:68] !== g.mask) begin
        $error("busiest_mask: expected %h, actual %h", g.mask, data[83:68]);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [NUM_W-1:0]  cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              out_tuser;

  grant_tracker tracker;
  bit           send_idle;
  bit           ready_idle;
  int           settings;

  next_free_server_allocator_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_request(input logic [TIME_W-1:0] arrival, input logic [TIME_W-1:0] load);
    int gap;
    gap = send_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {load, arrival};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(arrival, load);
  endtask

  task automatic drain_grants();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (tracker.pending_count() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (tracker.pending_count() != 0) begin
      $error("%0d requests never produced a result word", tracker.pending_count());
      tracker.errors++;
    end
  endtask

  task automatic write_ring(input logic [NUM_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_ring(v);
    settings++;
  endtask

  initial begin
    int                ring_plan [12];
    int                caps [4];
    int                load_cap;
    int                r;
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] ld;
    ring_plan   = '{16, 1, 8, 31, 5, 0, 2, 17, 12, 4, 16, 7};
    caps        = '{4, 16, 48, 120};
    tracker     = new();
    settings    = 0;
    send_idle   = 1'b1;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // three servers: fill, drop, refill, go back in time
    write_ring(5'd3);
    send_request(32'd0, 32'd10);
    send_request(32'd0, 32'd10);
    send_request(32'd0, 32'd10);
    send_request(32'd0, 32'd1);
    send_request(32'd10, 32'd1);
    send_request(32'd10, 32'd1);
    send_request(32'd4, 32'd3);
    drain_grants();
    // shrink below the start position
    write_ring(5'd0);
    send_request(32'd20, 32'd1);
    send_request(32'd21, 32'd2);
    drain_grants();
    write_ring(5'd31);
    send_request(32'd30, 32'd1);
    send_request(32'd30, 32'd1);

    base = 32'd40;
    ring_plan[11] = $urandom_range(0, 31);
    for (int p = 0; p < 12; p++) begin
      drain_grants();
      write_ring(NUM_W'(ring_plan[p]));
      send_idle = ($urandom_range(0, 3) != 0);
      load_cap  = caps[$urandom_range(0, 3)];
      repeat (95) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          arr = (base > 64) ? base - $urandom_range(0, 64) : '0;
        end else if (r < 6) begin
          base = base + $urandom_range(0, 1 << 23);
          arr  = base;
        end else begin
          base = base + $urandom_range(0, 4);
          arr  = base;
        end
        ld = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, load_cap);
        send_request(arr, ld);
      end
    end

    // top of the time range and full loads; servers may stay busy for good after this
    drain_grants();
    write_ring(5'd16);
    send_idle = 1'b1;
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd1);
    send_request(32'hFFFF_FFFF, 32'd1);
    send_request(32'd0, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 32'h8000_0000);
    repeat (12) begin
      arr = $urandom();
      ld  = $urandom();
      if (ld == 0) ld = 32'd1;
      send_request(arr, ld);
    end

    drain_grants();
    repeat (40) @(posedge clk);
    $display("Run covered %0d requests (%0d dropped) over %0d server-count settings,",
             tracker.requests, tracker.drops, settings);
    $display("with random gaps on both sides and one long receiver stall.");
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int gap;
    int taken;
    taken      = 0;
    ready_idle = 1'b1;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = ready_idle ? $urandom_range(0, 5) : 0;
      // hold off long enough to back up the input
      if (taken == 300) gap = 300;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      tracker.check_grant(out_tdata, out_tuser);
      taken++;
      if (taken % 50 == 0) ready_idle = $urandom_range(0, 1);
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/nfsa_pkg.sv
rtl/nfsa_alu.sv
rtl/next_free_server_allocator_unit.sv
dv/tb_next_free_server_allocator_unit.sv
